/* hw/rtl/array_linked_list_manager_macros.svh */
// Assertion helpers for the linked list manager.
`ifndef ARRAY_LINKED_LIST_MANAGER_MACROS_SVH
`define ARRAY_LINKED_LIST_MANAGER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ALM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("alm check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ALM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("alm check failed");

`endif

/* hw/rtl/alm_pkg.sv */
package alm_pkg;

    // field widths
    localparam int ACT_W  = 3;
    localparam int KEY_W  = 32;
    localparam int YEAR_W = 16;
    localparam int SEL_W  = 7;
    localparam int STAT_W = 3;
    localparam int IDX_W  = 7;
    localparam int CNT_W  = 8;

    // action codes
    localparam logic [ACT_W-1:0] ACT_INS_HEAD = 3'd0;
    localparam logic [ACT_W-1:0] ACT_INS_SORT = 3'd1;
    localparam logic [ACT_W-1:0] ACT_INS_TAIL = 3'd2;
    localparam logic [ACT_W-1:0] ACT_DEL_HEAD = 3'd3;
    localparam logic [ACT_W-1:0] ACT_DEL_MID  = 3'd4;
    localparam logic [ACT_W-1:0] ACT_DEL_TAIL = 3'd5;
    localparam logic [ACT_W-1:0] ACT_READ     = 3'd6;

    // status codes
    localparam logic [STAT_W-1:0] STAT_OK        = 3'd0;
    localparam logic [STAT_W-1:0] STAT_FULL      = 3'd1;
    localparam logic [STAT_W-1:0] STAT_EMPTY     = 3'd2;
    localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 3'd3;
    localparam logic [STAT_W-1:0] STAT_WRONG_POS = 3'd4;

    // shared key comparator result: a against b
    typedef struct packed {
        logic eq;
        logic lt;
        logic gt;
    } t_cmp;

endpackage

/* hw/rtl/alm_cmp.sv */
module alm_cmp (
    input  logic signed [alm_pkg::KEY_W-1:0] i_a,
    input  logic signed [alm_pkg::KEY_W-1:0] i_b,
    output alm_pkg::t_cmp                    o_res
);

    always_comb begin
        o_res.eq = (i_a == i_b);
        o_res.lt = (i_a < i_b);
        o_res.gt = (i_a > i_b);
    end

endmodule

/* hw/rtl/array_linked_list_manager.sv */
// Throughput: one item at a time; the walk is set by the single read port of the
//   slot memories (one node per cycle on search; the sorted walk reads and compares
//   in separate states) and one shared comparator.
// Reset: synchronous, active low; clears pointers, count and the fill mark. Slot
//   memories are not swept: slots at or above the fill mark read as their reset value.
`include "array_linked_list_manager_macros.svh"

module array_linked_list_manager #(
    parameter int SLOTS = 128
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // input channel
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [alm_pkg::ACT_W-1:0]          i_action,
    input  logic signed [alm_pkg::KEY_W-1:0]   i_key,
    input  logic [alm_pkg::YEAR_W-1:0]         i_year,
    input  logic [alm_pkg::SEL_W-1:0]          i_slot_sel,
    // output channel
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [alm_pkg::STAT_W-1:0]         o_status,
    output logic [alm_pkg::IDX_W-1:0]          o_slot_used,
    output logic signed [alm_pkg::KEY_W-1:0]   o_key_out,
    output logic [alm_pkg::YEAR_W-1:0]         o_year_out,
    output logic [alm_pkg::IDX_W-1:0]          o_next_out,
    output logic                               o_next_valid,
    output logic                               o_list_empty,
    output logic [alm_pkg::IDX_W-1:0]          o_head_out,
    output logic [alm_pkg::IDX_W-1:0]          o_tail_out,
    output logic [alm_pkg::CNT_W-1:0]          o_node_count
);

    localparam int AW = $clog2(SLOTS);      // slot index width
    localparam int LW = AW + 1;             // link entry: {valid, index}
    localparam int CW = $clog2(SLOTS + 1);  // count / fill mark, 0..SLOTS
    localparam logic [AW-1:0] LAST = AW'(SLOTS - 1);
    localparam int KW = alm_pkg::KEY_W;
    localparam int YW = alm_pkg::YEAR_W;

    // sequencer states
    localparam logic [4:0] S_IDLE     = 5'd0;
    localparam logic [4:0] S_INS_POP  = 5'd1;
    localparam logic [4:0] S_TAIL_WR  = 5'd2;
    localparam logic [4:0] S_SRT_RH   = 5'd3;
    localparam logic [4:0] S_SRT_CH   = 5'd4;
    localparam logic [4:0] S_SRT_CT   = 5'd5;
    localparam logic [4:0] S_WALK     = 5'd6;
    localparam logic [4:0] S_WALK_CMP = 5'd7;
    localparam logic [4:0] S_SRT_L1   = 5'd8;
    localparam logic [4:0] S_SRT_L2   = 5'd9;
    localparam logic [4:0] S_FIND     = 5'd10;
    localparam logic [4:0] S_DEL      = 5'd11;
    localparam logic [4:0] S_FREE     = 5'd12;
    localparam logic [4:0] S_DONE     = 5'd13;

    // slot memories, one shared read address and one shared write address
    logic [KW-1:0] key_mem  [SLOTS];
    logic [YW-1:0] year_mem [SLOTS];
    logic [LW-1:0] link_mem [SLOTS];

    // control state
    logic [4:0]  r_state, n_state;
    logic [AW-1:0] r_head, n_head;
    logic [AW-1:0] r_tail, n_tail;
    logic [AW-1:0] r_free, n_free;
    logic        r_head_ok, n_head_ok;
    logic        r_tail_ok, n_tail_ok;
    logic        r_free_ok, n_free_ok;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_fill, n_fill;      // slots at or above this were never written
    logic        r_out_valid, n_out_valid;

    // working registers of the current item
    logic [alm_pkg::ACT_W-1:0]  r_act, n_act;
    logic signed [KW-1:0]       r_key, n_key;
    logic [YW-1:0]              r_year, n_year;
    logic                       r_sel_ok, n_sel_ok;
    logic [alm_pkg::STAT_W-1:0] r_status, n_status;
    logic [AW-1:0] r_used, n_used;      // allocated / freed / read slot
    logic [AW-1:0] r_cur, n_cur;        // walk position, found slot on delete
    logic [AW-1:0] r_cur_link, n_cur_link;
    logic        r_cur_link_ok, n_cur_link_ok;
    logic [AW-1:0] r_prev, n_prev;
    logic        r_prev_ok, n_prev_ok;

    // memory read data
    logic [KW-1:0] r_rd_key;
    logic [YW-1:0] r_rd_year;
    logic [LW-1:0] r_rd_link;
    logic [AW-1:0] r_rd_addr;
    logic          r_rd_fresh;

    // memory port controls
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          wr_ky;
    logic          wr_l;
    logic [AW-1:0] wr_addr;
    logic [LW-1:0] wr_link;

    // output registers
    logic [alm_pkg::STAT_W-1:0] r_o_status;
    logic [alm_pkg::IDX_W-1:0]  r_o_used;
    logic [KW-1:0]              r_o_key;
    logic [YW-1:0]              r_o_year;
    logic [alm_pkg::IDX_W-1:0]  r_o_next;
    logic                       r_o_next_ok;
    logic                       r_o_empty;
    logic [alm_pkg::IDX_W-1:0]  r_o_head;
    logic [alm_pkg::IDX_W-1:0]  r_o_tail;
    logic [alm_pkg::CNT_W-1:0]  r_o_count;
    logic                       out_load;

    // effective read data: a never-written slot shows its reset contents
    logic signed [KW-1:0] eff_key;
    logic [YW-1:0]        eff_year;
    logic                 eff_link_ok;
    logic [AW-1:0]        eff_link;

    always_comb begin
        eff_key     = r_rd_fresh ? '0 : r_rd_key;
        eff_year    = r_rd_fresh ? '0 : r_rd_year;
        eff_link_ok = r_rd_fresh ? (r_rd_addr != LAST) : r_rd_link[AW];
        eff_link    = r_rd_fresh ? (r_rd_addr + AW'(1)) : r_rd_link[AW-1:0];
    end

    // the one key comparator: stored key (a) against item key (b)
    alm_pkg::t_cmp cmp;

    alm_cmp u_cmp (
        .i_a   (eff_key),
        .i_b   (r_key),
        .o_res (cmp)
    );

    assign out_load = (r_state == S_DONE) && (!r_out_valid || !i_out_stall);

    // sequencer
    always_comb begin
        n_state       = r_state;
        n_head        = r_head;
        n_tail        = r_tail;
        n_free        = r_free;
        n_head_ok     = r_head_ok;
        n_tail_ok     = r_tail_ok;
        n_free_ok     = r_free_ok;
        n_count       = r_count;
        n_fill        = r_fill;
        n_act         = r_act;
        n_key         = r_key;
        n_year        = r_year;
        n_sel_ok      = r_sel_ok;
        n_status      = r_status;
        n_used        = r_used;
        n_cur         = r_cur;
        n_cur_link    = r_cur_link;
        n_cur_link_ok = r_cur_link_ok;
        n_prev        = r_prev;
        n_prev_ok     = r_prev_ok;
        rd_en         = 1'b0;
        rd_addr       = r_head;
        wr_ky         = 1'b0;
        wr_l          = 1'b0;
        wr_addr       = r_used;
        wr_link       = '0;

        // output register drains independently of the sequencer
        n_out_valid = r_out_valid && i_out_stall;
        if (out_load) begin
            n_out_valid = 1'b1;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_act     = i_action;
                    n_key     = i_key;
                    n_year    = i_year;
                    n_sel_ok  = 1'b0;
                    n_status  = alm_pkg::STAT_OK;
                    n_used    = '0;
                    n_cur     = r_head;
                    n_prev    = '0;
                    n_prev_ok = 1'b0;
                    n_state   = S_DONE;
                    case (i_action)
                        alm_pkg::ACT_INS_HEAD, alm_pkg::ACT_INS_SORT,
                        alm_pkg::ACT_INS_TAIL: begin
                            if (!r_free_ok) begin
                                n_status = alm_pkg::STAT_FULL;
                            end else begin
                                // fetch the free slot's link to pop it
                                rd_en   = 1'b1;
                                rd_addr = r_free;
                                n_used  = r_free;
                                n_state = S_INS_POP;
                            end
                        end
                        alm_pkg::ACT_DEL_HEAD, alm_pkg::ACT_DEL_MID,
                        alm_pkg::ACT_DEL_TAIL: begin
                            if (!r_head_ok) begin
                                n_status = alm_pkg::STAT_EMPTY;
                            end else begin
                                rd_en   = 1'b1;
                                rd_addr = r_head;
                                n_state = S_FIND;
                            end
                        end
                        alm_pkg::ACT_READ: begin
                            if (32'(i_slot_sel) < 32'(SLOTS)) begin
                                rd_en    = 1'b1;
                                rd_addr  = AW'(i_slot_sel);
                                n_used   = AW'(i_slot_sel);
                                n_sel_ok = 1'b1;
                            end
                        end
                        default: begin
                            // unused code: plain status answer
                        end
                    endcase
                end
            end

            S_INS_POP: begin
                n_free    = eff_link;
                n_free_ok = eff_link_ok;
                n_count   = r_count + CW'(1);
                if (CW'(r_used) == r_fill) begin
                    n_fill = r_fill + CW'(1);
                end
                wr_ky   = 1'b1;
                wr_l    = 1'b1;
                wr_addr = r_used;
                wr_link = '0;
                if (!r_head_ok) begin
                    n_head    = r_used;
                    n_tail    = r_used;
                    n_head_ok = 1'b1;
                    n_tail_ok = 1'b1;
                    n_state   = S_DONE;
                end else if (r_act == alm_pkg::ACT_INS_HEAD) begin
                    wr_link = {1'b1, r_head};
                    n_head  = r_used;
                    n_state = S_DONE;
                end else if (r_act == alm_pkg::ACT_INS_TAIL) begin
                    n_state = S_TAIL_WR;
                end else begin
                    n_state = S_SRT_RH;
                end
            end

            S_TAIL_WR: begin
                wr_l    = 1'b1;
                wr_addr = r_tail;
                wr_link = {1'b1, r_used};
                n_tail  = r_used;
                n_state = S_DONE;
            end

            S_SRT_RH: begin
                rd_en   = 1'b1;
                rd_addr = r_head;
                n_state = S_SRT_CH;
            end

            S_SRT_CH: begin
                if (cmp.gt) begin
                    // new key below the head key: becomes the head
                    wr_l    = 1'b1;
                    wr_addr = r_used;
                    wr_link = {1'b1, r_head};
                    n_head  = r_used;
                    n_state = S_DONE;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = r_tail;
                    n_state = S_SRT_CT;
                end
            end

            S_SRT_CT: begin
                if (cmp.lt) begin
                    n_state = S_TAIL_WR;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = r_head;
                    n_cur   = r_head;
                    n_state = S_WALK;
                end
            end

            S_WALK: begin
                // read data holds the record at r_cur
                n_cur_link    = eff_link;
                n_cur_link_ok = eff_link_ok;
                if (eff_link_ok) begin
                    rd_en   = 1'b1;
                    rd_addr = eff_link;
                    n_state = S_WALK_CMP;
                end else begin
                    n_state = S_SRT_L1;
                end
            end

            S_WALK_CMP: begin
                if (cmp.lt) begin
                    n_cur   = r_cur_link;
                    n_state = S_WALK;
                end else begin
                    n_state = S_SRT_L1;
                end
            end

            S_SRT_L1: begin
                wr_l    = 1'b1;
                wr_addr = r_used;
                wr_link = {r_cur_link_ok, r_cur_link};
                if (!r_cur_link_ok) begin
                    n_tail = r_used;
                end
                n_state = S_SRT_L2;
            end

            S_SRT_L2: begin
                wr_l    = 1'b1;
                wr_addr = r_cur;
                wr_link = {1'b1, r_used};
                n_state = S_DONE;
            end

            S_FIND: begin
                // one node per cycle: compare, then fetch the successor
                if (cmp.eq) begin
                    n_cur_link    = eff_link;
                    n_cur_link_ok = eff_link_ok;
                    n_state       = S_DEL;
                end else begin
                    n_prev    = r_cur;
                    n_prev_ok = 1'b1;
                    if (eff_link_ok) begin
                        rd_en   = 1'b1;
                        rd_addr = eff_link;
                        n_cur   = eff_link;
                    end else begin
                        n_status = alm_pkg::STAT_NOT_FOUND;
                        n_state  = S_DONE;
                    end
                end
            end

            S_DEL: begin
                n_state = S_FREE;
                case (r_act)
                    alm_pkg::ACT_DEL_HEAD: begin
                        if (r_cur != r_head) begin
                            n_status = alm_pkg::STAT_WRONG_POS;
                            n_state  = S_DONE;
                        end else if (r_cur_link_ok) begin
                            n_head = r_cur_link;
                        end else begin
                            n_head_ok = 1'b0;
                            n_tail_ok = 1'b0;
                            n_head    = '0;
                            n_tail    = '0;
                        end
                    end
                    alm_pkg::ACT_DEL_MID: begin
                        if (r_cur == r_head || !r_cur_link_ok || !r_prev_ok) begin
                            n_status = alm_pkg::STAT_WRONG_POS;
                            n_state  = S_DONE;
                        end else begin
                            wr_l    = 1'b1;
                            wr_addr = r_prev;
                            wr_link = {1'b1, r_cur_link};
                        end
                    end
                    default: begin
                        // delete tail
                        if (!r_tail_ok || r_cur != r_tail) begin
                            n_status = alm_pkg::STAT_WRONG_POS;
                            n_state  = S_DONE;
                        end else if (r_cur == r_head || !r_prev_ok) begin
                            n_head_ok = 1'b0;
                            n_tail_ok = 1'b0;
                            n_head    = '0;
                            n_tail    = '0;
                        end else begin
                            n_tail  = r_prev;
                            wr_l    = 1'b1;
                            wr_addr = r_prev;
                            wr_link = '0;
                        end
                    end
                endcase
            end

            S_FREE: begin
                // push the removed slot onto the free chain
                wr_l      = 1'b1;
                wr_addr   = r_cur;
                wr_link   = {r_free_ok, r_free};
                n_free    = r_cur;
                n_free_ok = 1'b1;
                n_count   = r_count - CW'(1);
                n_used    = r_cur;
                n_state   = S_DONE;
            end

            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_free      <= '0;
            r_head_ok   <= 1'b0;
            r_tail_ok   <= 1'b0;
            r_free_ok   <= 1'b1;
            r_count     <= '0;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_free      <= n_free;
            r_head_ok   <= n_head_ok;
            r_tail_ok   <= n_tail_ok;
            r_free_ok   <= n_free_ok;
            r_count     <= n_count;
            r_fill      <= n_fill;
            r_out_valid <= n_out_valid;
        end
    end

    // working registers, no reset needed
    always_ff @(posedge i_clk) begin
        r_act         <= n_act;
        r_key         <= n_key;
        r_year        <= n_year;
        r_sel_ok      <= n_sel_ok;
        r_status      <= n_status;
        r_used        <= n_used;
        r_cur         <= n_cur;
        r_cur_link    <= n_cur_link;
        r_cur_link_ok <= n_cur_link_ok;
        r_prev        <= n_prev;
        r_prev_ok     <= n_prev_ok;
    end

    // slot memories
    always_ff @(posedge i_clk) begin
        if (wr_ky) begin
            key_mem[wr_addr]  <= r_key;
            year_mem[wr_addr] <= r_year;
        end
        if (wr_l) begin
            link_mem[wr_addr] <= wr_link;
        end
        if (rd_en) begin
            r_rd_key   <= key_mem[rd_addr];
            r_rd_year  <= year_mem[rd_addr];
            r_rd_link  <= link_mem[rd_addr];
            r_rd_addr  <= rd_addr;
            r_rd_fresh <= (CW'(rd_addr) >= r_fill);
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_o_status  <= r_status;
            r_o_used    <= alm_pkg::IDX_W'(r_used);
            r_o_key     <= r_sel_ok ? eff_key : '0;
            r_o_year    <= r_sel_ok ? eff_year : '0;
            r_o_next_ok <= r_sel_ok && eff_link_ok;
            r_o_next    <= (r_sel_ok && eff_link_ok) ? alm_pkg::IDX_W'(eff_link) : '0;
            r_o_empty   <= !r_head_ok;
            r_o_head    <= r_head_ok ? alm_pkg::IDX_W'(r_head) : '0;
            r_o_tail    <= r_tail_ok ? alm_pkg::IDX_W'(r_tail) : '0;
            r_o_count   <= alm_pkg::CNT_W'(r_count);
        end
    end

    assign o_in_stall   = (r_state != S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_status     = r_o_status;
    assign o_slot_used  = r_o_used;
    assign o_key_out    = r_o_key;
    assign o_year_out   = r_o_year;
    assign o_next_out   = r_o_next;
    assign o_next_valid = r_o_next_ok;
    assign o_list_empty = r_o_empty;
    assign o_head_out   = r_o_head;
    assign o_tail_out   = r_o_tail;
    assign o_node_count = r_o_count;

    // checks; head and count settle in different cycles of a delete
    `ALM_ASSERT_NOW(a_empty_count, i_clk, i_rst_n, r_state == S_IDLE, (!r_head_ok) == (r_count == '0))
    `ALM_ASSERT_NOW(a_ends_agree, i_clk, i_rst_n, 1'b1, r_head_ok == r_tail_ok)
    `ALM_ASSERT_NOW(a_full_chain, i_clk, i_rst_n, !r_free_ok, r_count == CW'(SLOTS))
    `ALM_ASSERT_NOW(a_fill_covers, i_clk, i_rst_n, 1'b1, r_fill >= r_count)
    `ALM_ASSERT_NEXT(a_busy_after_take, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall)

endmodule

/* tb/array_linked_list_manager_checker.sv */
`timescale 1ns / 1ps

module array_linked_list_manager_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    input  logic                               i_in_stall,
    input  logic [alm_pkg::ACT_W-1:0]          i_action,
    input  logic signed [alm_pkg::KEY_W-1:0]   i_key,
    input  logic [alm_pkg::YEAR_W-1:0]         i_year,
    input  logic [alm_pkg::SEL_W-1:0]          i_slot_sel,
    input  logic                               i_out_valid,
    input  logic                               i_out_stall,
    input  logic [alm_pkg::STAT_W-1:0]         i_status,
    input  logic [alm_pkg::IDX_W-1:0]          i_slot_used,
    input  logic signed [alm_pkg::KEY_W-1:0]   i_key_out,
    input  logic [alm_pkg::YEAR_W-1:0]         i_year_out,
    input  logic [alm_pkg::IDX_W-1:0]          i_next_out,
    input  logic                               i_next_valid,
    input  logic                               i_list_empty,
    input  logic [alm_pkg::IDX_W-1:0]          i_head_out,
    input  logic [alm_pkg::IDX_W-1:0]          i_tail_out,
    input  logic [alm_pkg::CNT_W-1:0]          i_node_count,
    output int                                 o_fail_count,
    output int                                 o_pending
);

    localparam int SLOTS = 128;
    localparam int KEY_W = alm_pkg::KEY_W;
    localparam int IDX_W = alm_pkg::IDX_W;
    localparam int CNT_W = alm_pkg::CNT_W;

    typedef struct packed {
        logic [alm_pkg::STAT_W-1:0] status;
        logic [IDX_W-1:0]           slot_used;
        logic signed [KEY_W-1:0]    key_out;
        logic [alm_pkg::YEAR_W-1:0] year_out;
        logic [IDX_W-1:0]           next_out;
        logic                       next_valid;
        logic                       list_empty;
        logic [IDX_W-1:0]           head_out;
        logic [IDX_W-1:0]           tail_out;
        logic [CNT_W-1:0]           node_count;
    } t_list_result;

    // shadow of the slot store and its pointers
    logic signed [KEY_W-1:0]    node_key  [SLOTS];
    logic [alm_pkg::YEAR_W-1:0] node_year [SLOTS];
    logic [IDX_W-1:0]           node_link [SLOTS];
    logic                       node_link_ok [SLOTS];
    logic [IDX_W-1:0]           first_slot, last_slot, spare_slot;
    logic                       first_ok, last_ok, spare_ok;
    logic [CNT_W-1:0]           node_total;

    t_list_result expected_results[$];
    int           fail_count = 0;

    task automatic clear_store();
        for (int i = 0; i < SLOTS; i++) begin
            node_key[i]     = '0;
            node_year[i]    = '0;
            node_link[i]    = IDX_W'(i + 1);
            node_link_ok[i] = (i + 1 < SLOTS);
        end
        first_slot = '0;
        last_slot  = '0;
        first_ok   = 1'b0;
        last_ok    = 1'b0;
        spare_slot = '0;
        spare_ok   = 1'b1;
        node_total = '0;
    endtask

    // first node from the head holding key k, and the node before it
    function automatic bit find_node(input logic signed [KEY_W-1:0] k,
                                     output logic [IDX_W-1:0] hit,
                                     output logic [IDX_W-1:0] prev,
                                     output bit prev_ok);
        logic [IDX_W-1:0] cur;
        bit               ok;
        cur     = first_slot;
        ok      = first_ok;
        hit     = '0;
        prev    = '0;
        prev_ok = 1'b0;
        for (int steps = 0; ok && steps < SLOTS; steps++) begin
            if (node_key[cur] == k) begin
                hit = cur;
                return 1'b1;
            end
            prev    = cur;
            prev_ok = 1'b1;
            ok      = node_link_ok[cur];
            cur     = node_link[cur];
        end
        return 1'b0;
    endfunction

    task automatic release_slot(input logic [IDX_W-1:0] s);
        node_link[s]    = spare_slot;
        node_link_ok[s] = spare_ok;
        spare_slot      = s;
        spare_ok        = 1'b1;
        node_total      = node_total - 1'b1;
    endtask

    task automatic drop_all();
        first_ok   = 1'b0;
        last_ok    = 1'b0;
        first_slot = '0;
        last_slot  = '0;
    endtask

    task automatic apply_action(input logic [alm_pkg::ACT_W-1:0] act,
                                input logic signed [KEY_W-1:0] k,
                                input logic [alm_pkg::YEAR_W-1:0] yr,
                                input logic [alm_pkg::SEL_W-1:0] sel,
                                output t_list_result r);
        logic [IDX_W-1:0] s, prev, cur;
        bit               prev_ok;
        int               steps;
        r = '0;
        r.status = alm_pkg::STAT_OK;
        case (act)
            alm_pkg::ACT_INS_HEAD, alm_pkg::ACT_INS_SORT, alm_pkg::ACT_INS_TAIL: begin
                if (!spare_ok) begin
                    r.status = alm_pkg::STAT_FULL;
                end else begin
                    s               = spare_slot;
                    spare_ok        = node_link_ok[s];
                    spare_slot      = node_link[s];
                    node_key[s]     = k;
                    node_year[s]    = yr;
                    node_link_ok[s] = 1'b0;
                    node_link[s]    = '0;
                    if (!first_ok) begin
                        first_slot = s;
                        first_ok   = 1'b1;
                        last_slot  = s;
                        last_ok    = 1'b1;
                    end else if (act == alm_pkg::ACT_INS_HEAD ||
                                 (act == alm_pkg::ACT_INS_SORT &&
                                  k < node_key[first_slot])) begin
                        node_link[s]    = first_slot;
                        node_link_ok[s] = 1'b1;
                        first_slot      = s;
                    end else if (act == alm_pkg::ACT_INS_TAIL || k > node_key[last_slot]) begin
                        node_link[last_slot]    = s;
                        node_link_ok[last_slot] = 1'b1;
                        last_slot               = s;
                    end else begin
                        cur   = first_slot;
                        steps = 0;
                        while (node_link_ok[cur] && node_key[node_link[cur]] < k &&
                               steps < SLOTS) begin
                            cur = node_link[cur];
                            steps++;
                        end
                        node_link[s]      = node_link[cur];
                        node_link_ok[s]   = node_link_ok[cur];
                        node_link[cur]    = s;
                        node_link_ok[cur] = 1'b1;
                        if (!node_link_ok[s])
                            last_slot = s;
                    end
                    node_total  = node_total + 1'b1;
                    r.slot_used = s;
                end
            end
            alm_pkg::ACT_DEL_HEAD, alm_pkg::ACT_DEL_MID, alm_pkg::ACT_DEL_TAIL: begin
                if (!first_ok) begin
                    r.status = alm_pkg::STAT_EMPTY;
                end else if (!find_node(k, s, prev, prev_ok)) begin
                    r.status = alm_pkg::STAT_NOT_FOUND;
                end else if (act == alm_pkg::ACT_DEL_HEAD) begin
                    if (s != first_slot) begin
                        r.status = alm_pkg::STAT_WRONG_POS;
                    end else begin
                        if (node_link_ok[s])
                            first_slot = node_link[s];
                        else
                            drop_all();
                        release_slot(s);
                        r.slot_used = s;
                    end
                end else if (act == alm_pkg::ACT_DEL_MID) begin
                    if (s == first_slot || !node_link_ok[s] || !prev_ok) begin
                        r.status = alm_pkg::STAT_WRONG_POS;
                    end else begin
                        node_link[prev]    = node_link[s];
                        node_link_ok[prev] = 1'b1;
                        release_slot(s);
                        r.slot_used = s;
                    end
                end else begin
                    if (!last_ok || s != last_slot) begin
                        r.status = alm_pkg::STAT_WRONG_POS;
                    end else begin
                        if (s == first_slot || !prev_ok) begin
                            drop_all();
                        end else begin
                            last_slot          = prev;
                            node_link_ok[prev] = 1'b0;
                            node_link[prev]    = '0;
                        end
                        release_slot(s);
                        r.slot_used = s;
                    end
                end
            end
            alm_pkg::ACT_READ: begin
                r.slot_used  = sel;
                r.key_out    = node_key[sel];
                r.year_out   = node_year[sel];
                r.next_valid = node_link_ok[sel];
                r.next_out   = node_link_ok[sel] ? node_link[sel] : '0;
            end
            default: ;
        endcase
        r.list_empty = !first_ok;
        r.head_out   = first_ok ? first_slot : '0;
        r.tail_out   = last_ok ? last_slot : '0;
        r.node_count = node_total;
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_list_result want, got;
        if (!i_rst_n) begin
            clear_store();
            expected_results.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                got = '{i_status, i_slot_used, i_key_out, i_year_out, i_next_out,
                        i_next_valid, i_list_empty, i_head_out, i_tail_out, i_node_count};
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected item, expected none actual status %0h slot %0h",
                             $time, got.status, got.slot_used);
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("status", want.status, got.status);
                    check_field("slot_used", want.slot_used, got.slot_used);
                    check_field("key_out", want.key_out, got.key_out);
                    check_field("year_out", want.year_out, got.year_out);
                    check_field("next_out", want.next_out, got.next_out);
                    check_field("next_valid", want.next_valid, got.next_valid);
                    check_field("list_empty", want.list_empty, got.list_empty);
                    check_field("head_out", want.head_out, got.head_out);
                    check_field("tail_out", want.tail_out, got.tail_out);
                    check_field("node_count", want.node_count, got.node_count);
                end
            end
            if (i_in_valid && !i_in_stall) begin
                apply_action(i_action, i_key, i_year, i_slot_sel, want);
                expected_results.push_back(want);
            end
        end
        o_fail_count <= fail_count;
        o_pending    <= expected_results.size();
    end

endmodule

/* tb/array_linked_list_manager_test.sv */
`timescale 1ns / 1ps

module array_linked_list_manager_test;

    localparam int ACT_W  = alm_pkg::ACT_W;
    localparam int KEY_W  = alm_pkg::KEY_W;
    localparam int YEAR_W = alm_pkg::YEAR_W;
    localparam int SEL_W  = alm_pkg::SEL_W;
    localparam int IDX_W  = alm_pkg::IDX_W;

    // action code the block treats as a no-op
    localparam logic [ACT_W-1:0] ACT_UNUSED = 3'd7;

    localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
    localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;

    localparam logic [ACT_W-1:0] INS_CODES [3] =
        '{alm_pkg::ACT_INS_HEAD, alm_pkg::ACT_INS_SORT, alm_pkg::ACT_INS_TAIL};
    localparam logic [ACT_W-1:0] DEL_CODES [3] =
        '{alm_pkg::ACT_DEL_HEAD, alm_pkg::ACT_DEL_MID, alm_pkg::ACT_DEL_TAIL};

    // long receiver hold-off: starts once this many items went in
    localparam int HOLD_AT        = 300;
    localparam int HOLD_CYCLES    = 400;
    // worst legal quiet stretch is the hold-off plus a full sorted walk
    // plus a sender gap; keep a wide margin
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 300;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    // input channel, all driven at the falling edge
    logic                     in_valid  = 1'b0;
    logic [ACT_W-1:0]         in_action = '0;
    logic signed [KEY_W-1:0]  in_key    = '0;
    logic [YEAR_W-1:0]        in_year   = '0;
    logic [SEL_W-1:0]         in_sel    = '0;
    logic                     o_in_stall;

    // output channel
    logic                               out_stall = 1'b0;
    logic                               o_out_valid;
    logic [alm_pkg::STAT_W-1:0]         o_status;
    logic [IDX_W-1:0]                   o_slot_used;
    logic signed [KEY_W-1:0]            o_key_out;
    logic [YEAR_W-1:0]                  o_year_out;
    logic [IDX_W-1:0]                   o_next_out;
    logic                               o_next_valid;
    logic                               o_list_empty;
    logic [IDX_W-1:0]                   o_head_out;
    logic [IDX_W-1:0]                   o_tail_out;
    logic [alm_pkg::CNT_W-1:0]          o_node_count;

    int err_count;
    int pending;
    int sent_count  = 0;
    int burst_left  = 1;
    int idle_cycles = 0;

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    array_linked_list_manager #(.SLOTS(128)) u_top (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .o_in_stall   (o_in_stall),
        .i_action     (in_action),
        .i_key        (in_key),
        .i_year       (in_year),
        .i_slot_sel   (in_sel),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (out_stall),
        .o_status     (o_status),
        .o_slot_used  (o_slot_used),
        .o_key_out    (o_key_out),
        .o_year_out   (o_year_out),
        .o_next_out   (o_next_out),
        .o_next_valid (o_next_valid),
        .o_list_empty (o_list_empty),
        .o_head_out   (o_head_out),
        .o_tail_out   (o_tail_out),
        .o_node_count (o_node_count)
    );

    array_linked_list_manager_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (o_in_stall),
        .i_action     (in_action),
        .i_key        (in_key),
        .i_year       (in_year),
        .i_slot_sel   (in_sel),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (out_stall),
        .i_status     (o_status),
        .i_slot_used  (o_slot_used),
        .i_key_out    (o_key_out),
        .i_year_out   (o_year_out),
        .i_next_out   (o_next_out),
        .i_next_valid (o_next_valid),
        .i_list_empty (o_list_empty),
        .i_head_out   (o_head_out),
        .i_tail_out   (o_tail_out),
        .i_node_count (o_node_count),
        .o_fail_count (err_count),
        .o_pending    (pending)
    );

    // Offer one item from a falling edge and hold it until it is taken.
    // Returns at the falling edge after the accepting rising edge, with
    // valid still high so a following item continues without a bubble.
    task automatic send_item(input logic [ACT_W-1:0] act,
                             input logic signed [KEY_W-1:0] k,
                             input logic [YEAR_W-1:0] yr,
                             input logic [SEL_W-1:0] sel);
        in_valid  <= 1'b1;
        in_action <= act;
        in_key    <= k;
        in_year   <= yr;
        in_sel    <= sel;
        @(posedge clk);
        while (o_in_stall)
            @(posedge clk);
        sent_count++;
        @(negedge clk);
    endtask

    task automatic pause(input int cycles);
        in_valid <= 1'b0;
        repeat (cycles) @(negedge clk);
    endtask

    // span > 0: mostly keys from a narrow window around zero so deletes hit
    // and duplicates show up; otherwise extremes and full-range keys
    function automatic logic signed [KEY_W-1:0] pick_key(input int span);
        int r;
        r = $urandom_range(99);
        if (span > 0 && r < 85)
            return int'($urandom_range(span - 1)) - span / 2;
        if (r < 93) begin
            case ($urandom_range(3))
                0: return KEY_MIN;
                1: return KEY_MAX;
                2: return '0;
                default: return -1;
            endcase
        end
        return $urandom;
    endfunction

    // One phase of random traffic with a given action mix. Reads take the rest
    // up to 97 percent, and the last 3 percent of draws carry the unused action code.
    task automatic run_phase(input int items, input int ins_pct, input int del_pct,
                             input int span, input bit gaps);
        int r;
        logic [ACT_W-1:0] act;
        for (int n = 0; n < items; n++) begin
            r = $urandom_range(99);
            if (r < ins_pct)
                act = INS_CODES[$urandom_range(2)];
            else if (r < ins_pct + del_pct)
                act = DEL_CODES[$urandom_range(2)];
            else if (r < 97)
                act = alm_pkg::ACT_READ;
            else
                act = ACT_UNUSED;
            send_item(act, pick_key(span), YEAR_W'($urandom), SEL_W'($urandom));
            // sender bursts: random length, random gap (sometimes long)
            burst_left--;
            if (burst_left <= 0) begin
                if (gaps)
                    pause(($urandom_range(9) == 0) ? $urandom_range(20, 40)
                                                   : $urandom_range(1, 12));
                burst_left = $urandom_range(1, 24);
            end
        end
    endtask

    // Receiver: stall density changes from one window of random length to the next,
    // including windows of no stall at all. One long hold-off lets the block fill up
    // and push back on its input while the sender keeps offering.
    initial begin : rx_side
        int  pct;
        int  left;
        bit  held;
        pct  = 0;
        left = 0;
        held = 1'b0;
        forever begin
            @(negedge clk);
            if (!held && sent_count >= HOLD_AT) begin
                held = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            if (left == 0) begin
                left = $urandom_range(16, 96);
                case ($urandom_range(3))
                    0: pct = 0;
                    1: pct = 20;
                    2: pct = 50;
                    default: pct = 85;
                endcase
            end
            left--;
            out_stall <= ($urandom_range(99) < pct);
        end
    end

    // Watchdog: cycles with no handshake on either side.
    always @(posedge clk) begin
        if (!rst_n || (in_valid && !o_in_stall) || (o_out_valid && !out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // --- directed ---
        // reads of untouched slots: zero contents, chained free links,
        // last slot has no link
        send_item(alm_pkg::ACT_READ, '0, '0, 7'd0);
        send_item(alm_pkg::ACT_READ, '0, '0, 7'd127);
        // deletes on an empty list, then the unused code
        send_item(alm_pkg::ACT_DEL_HEAD, '0, '0, '0);
        send_item(alm_pkg::ACT_DEL_MID, '0, '0, '0);
        send_item(alm_pkg::ACT_DEL_TAIL, '0, '0, '0);
        send_item(ACT_UNUSED, KEY_MAX, 16'hFFFF, 7'h7F);
        // build MIN, 3, 5, MAX with field extremes
        send_item(alm_pkg::ACT_INS_HEAD, KEY_MIN, 16'h0000, '0);
        send_item(alm_pkg::ACT_INS_TAIL, KEY_MAX, 16'hFFFF, '0);
        send_item(alm_pkg::ACT_INS_SORT, 32'sd5, 16'h1234, '0);
        send_item(alm_pkg::ACT_INS_SORT, 32'sd3, 16'hABCD, '0);
        // delete head where the head does not match: found elsewhere / nowhere
        send_item(alm_pkg::ACT_DEL_HEAD, 32'sd5, '0, '0);
        send_item(alm_pkg::ACT_DEL_HEAD, 32'sd77, '0, '0);
        // delete middle aimed at either end, then a real middle node
        send_item(alm_pkg::ACT_DEL_MID, KEY_MIN, '0, '0);
        send_item(alm_pkg::ACT_DEL_MID, KEY_MAX, '0, '0);
        send_item(alm_pkg::ACT_DEL_MID, 32'sd3, '0, '0);
        // delete tail on a non-tail match, then the real tail
        send_item(alm_pkg::ACT_DEL_TAIL, 32'sd5, '0, '0);
        send_item(alm_pkg::ACT_DEL_TAIL, KEY_MAX, '0, '0);
        // sorted insert beyond the last key becomes the new tail
        send_item(alm_pkg::ACT_INS_SORT, 32'sd1000, 16'h00FF, '0);
        send_item(alm_pkg::ACT_READ, '0, '0, 7'd1);
        send_item(alm_pkg::ACT_READ, '0, '0, 7'd2);
        // sorted insert below the head, plain head insert on a busy list
        send_item(alm_pkg::ACT_DEL_HEAD, KEY_MIN, '0, '0);
        send_item(alm_pkg::ACT_INS_SORT, -32'sd5, 16'h8000, '0);
        send_item(alm_pkg::ACT_INS_HEAD, -32'sd9, 16'h0001, '0);
        // empty the list from both ends; the last node goes via a tail delete
        send_item(alm_pkg::ACT_DEL_TAIL, 32'sd1000, '0, '0);
        send_item(alm_pkg::ACT_DEL_HEAD, -32'sd9, '0, '0);
        send_item(alm_pkg::ACT_DEL_HEAD, -32'sd5, '0, '0);
        send_item(alm_pkg::ACT_DEL_TAIL, 32'sd5, '0, '0);

        // --- random ---
        run_phase(250, 45, 40, 16, 1'b1);   // mixed traffic, short lists
        run_phase(250, 85, 10, 4, 1'b1);    // fill up, hit store-full
        run_phase(350, 10, 85, 4, 1'b0);    // drain, back to back
        run_phase(400, 40, 40, 0, 1'b1);    // wide keys and extremes

        in_valid <= 1'b0;

        // let every expected item come out, then a little more
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (err_count == 0 && pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
